@@ hw/rtl/sfas_pkg.sv @@
// shared types and constants for the truncating single-precision adder
`default_nettype none
package sfas_pkg;
  localparam int unsigned QueueDepth = 2;
  localparam logic [23:0] HiddenBit = 24'h800000;
  localparam logic [7:0] ExpInf = 8'hFF;
  localparam logic [3:0] NearLimit = 4'd8;

  typedef struct packed {
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic        mode;
  } in_item_t;

  typedef struct packed {
    logic [31:0] sum_bits;
    logic        range_error;
  } out_item_t;

  // classified operation handed from front to back
  typedef struct packed {
    logic        cancel;
    logic        near;
    logic        sub;
    logic        sign;
    logic [7:0]  exp_large;
    logic [7:0]  exp_small;
    logic [23:0] sig_large;
    logic [23:0] sig_small;
    logic [7:0]  diff;
  } op_t;
endpackage
`default_nettype wire

@@ hw/rtl/sfas_if.sv @@
// valid/ready channel interfaces
`default_nettype none
interface sfas_in_if;
  logic valid;
  logic ready;
  sfas_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface sfas_out_if;
  logic valid;
  logic ready;
  sfas_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/single_float_add_sub_truncating.sv @@
// path: an input passes the front, queue, add and normalize registers on its way to the result
// throughput: one item per cycle while the output is ready; the queue lets front and back stall independently
// the adder stage and the normalize stage each hold one item
// reset: synchronous active-high rst empties all stages and the queue
// top level of the truncating single-precision adder/subtractor
`default_nettype none
module single_float_add_sub_truncating #(
  parameter int unsigned QDepth = sfas_pkg::QueueDepth
) (
  input wire logic clk,
  input wire logic rst,
  sfas_in_if.sink  in_ch,
  sfas_out_if.source out_ch
);
  import sfas_pkg::*;
  logic f_valid, f_ready, b_valid, b_ready;
  op_t f_data, b_data;

  sfas_front u_front (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .op_valid(f_valid), .op_ready(f_ready), .op_data(f_data)
  );

  sfas_queue #(.Depth(QDepth)) u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
  );

  sfas_back u_back (
    .clk, .rst,
    .op_valid(b_valid), .op_ready(b_ready), .op_data(b_data),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res_data(out_ch.data)
  );
endmodule
`default_nettype wire

@@ hw/rtl/sfas_front.sv @@
// front: unpacks, orders operands by magnitude and classifies
`default_nettype none
module sfas_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire sfas_pkg::in_item_t in_data,
  output logic                 op_valid,
  input  wire logic            op_ready,
  output sfas_pkg::op_t        op_data
);
  import sfas_pkg::*;
  logic       sa, sb, swap;
  logic [7:0] ea, eb;
  logic [22:0] ma, mb;
  op_t op_next;

  always_comb begin
    sa = in_data.operand_a[31];
    ea = in_data.operand_a[30:23];
    ma = in_data.operand_a[22:0];
    sb = in_data.operand_b[31] ^ in_data.mode;
    eb = in_data.operand_b[30:23];
    mb = in_data.operand_b[22:0];
    swap = (eb > ea) || ((eb == ea) && (mb > ma));
    op_next.cancel = (ea == eb) && (ma == mb) && (sa != sb);
    op_next.sub = sa != sb;
    op_next.sign = swap ? sb : sa;
    op_next.exp_large = swap ? eb : ea;
    op_next.exp_small = swap ? ea : eb;
    op_next.sig_large = HiddenBit | {1'b0, swap ? mb : ma};
    op_next.sig_small = HiddenBit | {1'b0, swap ? ma : mb};
    op_next.diff = op_next.exp_large - op_next.exp_small;
    op_next.near = op_next.diff <= {4'd0, NearLimit};
  end

  assign in_ready = !op_valid || op_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (in_ready) begin
      op_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      op_data <= op_next;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/sfas_queue.sv @@
// small fifo between front and back
`default_nettype none
module sfas_queue #(
  parameter int unsigned Depth = sfas_pkg::QueueDepth
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  wire sfas_pkg::op_t wr_data,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output sfas_pkg::op_t      rd_data
);
  import sfas_pkg::*;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  op_t mem [Depth];
  logic [AW-1:0] wp, rp;
  logic [AW:0] count;
  logic wr_en, rd_en;

  assign wr_ready = count < (AW+1)'(Depth);
  assign rd_valid = count != '0;
  assign wr_en = wr_valid && wr_ready;
  assign rd_en = rd_valid && rd_ready;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wp <= (wp == AW'(Depth - 1)) ? '0 : wp + 1'b1;
      end
      if (rd_en) begin
        rp <= (rp == AW'(Depth - 1)) ? '0 : rp + 1'b1;
      end
      count <= count + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(Depth)) else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    wr_en && !rd_en |=> count == $past(count) + 1'b1) else $error("count did not rise");
  a_count_dn: assert property (@(posedge clk) disable iff (rst)
    rd_en && !wr_en |=> count == $past(count) - 1'b1) else $error("count did not fall");
`endif
endmodule
`default_nettype wire

@@ hw/rtl/sfas_back.sv @@
// back: aligns, adds, normalizes with truncation and packs
`default_nettype none
module sfas_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          op_valid,
  output logic               op_ready,
  input  wire sfas_pkg::op_t op_data,
  output logic               res_valid,
  input  wire logic          res_ready,
  output sfas_pkg::out_item_t res_data
);
  import sfas_pkg::*;
  // stage 1: alignment and add
  logic        s1_valid;
  logic [32:0] s1_sum;
  logic signed [9:0] s1_exp;
  logic        s1_sign, s1_cancel;
  logic        s1_ready;
  logic [32:0] big, addend, sum_next;
  logic [23:0] sh_small;

  always_comb begin
    big = {9'd0, op_data.sig_large} << op_data.diff[3:0];
    sh_small = (op_data.diff >= 8'd32) ? 24'd0 : op_data.sig_small >> op_data.diff[4:0];
    if (op_data.near) begin
      addend = {9'd0, op_data.sig_small};
    end else begin
      big = {9'd0, op_data.sig_large};
      addend = {9'd0, sh_small};
    end
    sum_next = op_data.sub ? big - addend : big + addend;
  end

  assign s1_ready = !res_valid || res_ready;
  assign op_ready = !s1_valid || s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (op_ready) begin
      s1_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op_ready && op_valid) begin
      s1_sum <= sum_next;
      s1_exp <= {2'b00, op_data.near ? op_data.exp_small : op_data.exp_large};
      s1_sign <= op_data.sign;
      s1_cancel <= op_data.cancel;
    end
  end

  // stage 2: normalize with floor at biased exponent 1
  logic [5:0] msb;
  logic [4:0] lz, lim;
  logic [32:0] norm;
  logic signed [9:0] rexp;
  out_item_t res_next;

  always_comb begin
    msb = '0;
    for (int i = 0; i < 33; i++) begin
      if (s1_sum[i]) msb = 6'(i);
    end
    norm = s1_sum;
    rexp = s1_exp;
    lz = '0;
    lim = '0;
    if (msb > 6'd23) begin
      norm = s1_sum >> (msb - 6'd23);
      rexp = s1_exp + 10'(msb - 6'd23);
    end else if (s1_sum != '0) begin
      lz = 5'(6'd23 - msb);
      // shift left no further than exponent 1
      lim = (s1_exp <= 10'sd1) ? 5'd0 :
            ((s1_exp - 10'sd1) < 10'sd24 ? 5'(s1_exp - 10'sd1) : 5'd23);
      if (lz > lim) lz = lim;
      norm = s1_sum << lz;
      rexp = s1_exp - 10'(lz);
    end else begin
      lim = (s1_exp <= 10'sd1) ? 5'd0 : 5'd23;
      rexp = (s1_exp <= 10'sd1) ? s1_exp : 10'sd1;
    end
    res_next.range_error = 1'b0;
    if (s1_cancel) begin
      res_next.sum_bits = '0;
    end else if (rexp >= 10'sd255) begin
      res_next.sum_bits = {s1_sign, ExpInf, 23'd0};
      res_next.range_error = 1'b1;
    end else if (rexp < 10'sd0) begin
      res_next.sum_bits = {s1_sign, 31'd0};
      res_next.range_error = 1'b1;
    end else begin
      res_next.sum_bits = {s1_sign, rexp[7:0], norm[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_ready) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      res_data <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data)) else $error("result dropped");
  a_inf_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.range_error |-> res_data.sum_bits[30:23] == ExpInf)
    else $error("flag without saturation");
  a_s1_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_ready |=> s1_valid) else $error("stage lost");
`endif
endmodule
`default_nettype wire

@@ tb/sfas_checker.sv @@
// checker for the truncating single-precision adder: predicts sums and compares results
module sfas_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  sfas_pkg::in_item_t in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  sfas_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending_sums,
  output int                 sums_checked
);
  import sfas_pkg::*;

  out_item_t expected_sums[$];

  function automatic out_item_t truncated_sum(in_item_t op);
    logic        sa, sb, ls, ss;
    logic [7:0]  ea, eb, le, se;
    logic [22:0] ma, mb, lm, sm;
    logic [7:0]  diff;
    logic [63:0] rm, big, shifted;
    int          rexp;
    out_item_t   res;
    sa = op.operand_a[31]; ea = op.operand_a[30:23]; ma = op.operand_a[22:0];
    sb = op.operand_b[31] ^ op.mode; eb = op.operand_b[30:23]; mb = op.operand_b[22:0];
    res = '0;
    if (ea == eb && ma == mb && sa != sb) return res;
    if (eb > ea || (eb == ea && mb > ma)) begin
      ls = sb; le = eb; lm = mb; ss = sa; se = ea; sm = ma;
    end else begin
      ls = sa; le = ea; lm = ma; ss = sb; se = eb; sm = mb;
    end
    diff = le - se;
    if (diff <= 8) begin
      big = {40'd0, 1'b1, lm} << diff;
      rexp = se;
      rm = (ls != ss) ? big - {40'd0, 1'b1, sm} : big + {40'd0, 1'b1, sm};
    end else begin
      shifted = (diff >= 32) ? 64'd0 : ({40'd0, 1'b1, sm} >> diff);
      rexp = le;
      rm = (ls != ss) ? {40'd0, 1'b1, lm} - shifted : {40'd0, 1'b1, lm} + shifted;
    end
    while (rm > 64'hFFFFFF) begin
      rm = rm >> 1;
      rexp++;
    end
    while (rm < 64'h800000 && rexp > 1) begin
      rm = rm << 1;
      rexp--;
    end
    if (rexp >= 255) begin
      res.sum_bits = {ls, 31'h7F800000};
      res.range_error = 1'b1;
    end else if (rexp < 0) begin
      res.sum_bits = {ls, 31'd0};
      res.range_error = 1'b1;
    end else begin
      res.sum_bits = {ls, rexp[7:0], rm[22:0]};
    end
    return res;
  endfunction

  assign pending_sums = expected_sums.size();

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      fail_count <= 0;
      sums_checked <= 0;
      expected_sums.delete();
    end else begin
      if (in_valid && in_ready) expected_sums.push_back(truncated_sum(in_data));
      if (out_valid && out_ready) begin
        sums_checked <= sums_checked + 1;
        if (expected_sums.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h err %b", out_data.sum_bits,
                                        out_data.range_error);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_sums.pop_front();
          if (want.sum_bits !== out_data.sum_bits
              || want.range_error !== out_data.range_error) begin
            if (fail_count < 10)
              $display("mismatch: expected %h err %b, got %h err %b", want.sum_bits,
                       want.range_error, out_data.sum_bits, out_data.range_error);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ tb/single_float_add_sub_truncating_tb.sv @@
// stimulus and verdict for the truncating single-precision adder
module single_float_add_sub_truncating_tb;
  import sfas_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, pending_sums, sums_checked;
  int   send_idle = 0, recv_stall = 0;
  bit   hold_off = 1'b0;
  int   quiet_cycles = 0;
  bit   in_flight = 1'b1;

  sfas_in_if  in_ch();
  sfas_out_if out_ch();

  single_float_add_sub_truncating DUT (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  sfas_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .fail_count(fail_count), .pending_sums(pending_sums), .sums_checked(sums_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // receiver: random stalls, or a long hold-off
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall);
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (!rst && ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
      quiet_cycles <= 0;
    else if (!rst && in_flight) quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("timeout waiting for a transfer");
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [31:0] random_float();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(7))
      0: v[30:23] = 8'hFF;
      1: v[30:23] = 8'h00;
      2: v[30:23] = 8'hFE;
      3: v[22:0] = $urandom_range(1) ? 23'h7FFFFF : 23'h0;
      default: ;
    endcase
    return v;
  endfunction

  // valid stays high between back-to-back transfers and drops only for idle gaps
  task automatic send(logic [31:0] a, logic [31:0] b, logic m);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= '{operand_a: a, operand_b: b, mode: m};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_random(int n);
    logic [31:0] a, b;
    repeat (n) begin
      a = random_float();
      b = random_float();
      case ($urandom_range(5))
        0: b = a;                                    // cancellation or doubling
        1: b = {$urandom_range(1) ? 1'b1 : 1'b0, a[30:23] + 8'($urandom_range(8)),
                23'($urandom())};                    // near alignment
        2: b = {a[31:23], 23'($urandom())};          // equal exponents
        default: ;
      endcase
      send(a, b, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send(32'h3F800000, 32'h3F800000, 1'b0);
    send(32'h3F800000, 32'h3F800000, 1'b1);   // exact cancellation
    send(32'h3F800000, 32'hBF800000, 1'b0);
    send(32'h7F7FFFFF, 32'h7F7FFFFF, 1'b0);   // overflow
    send(32'h7F800000, 32'h3F800000, 1'b1);
    send(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
    send(32'h00000000, 32'h00000000, 1'b0);
    send(32'h00000000, 32'h80000000, 1'b0);
    send(32'h00800000, 32'h00000001, 1'b1);   // left shift stops at exponent 1
    send(32'h00000001, 32'h00000000, 1'b1);
    send(32'h3F800001, 32'h3F800000, 1'b1);   // deep cancellation
    send(32'h40000000, 32'h3B800000, 1'b0);   // diff 9, far path
    send(32'h40000000, 32'h3B000000, 1'b1);   // diff 10, far path
    send(32'h4B800000, 32'h33FFFFFF, 1'b1);
    send(32'h7F000000, 32'h00000000, 1'b0);   // very far
    send(32'h3F800000, 32'h3F800001, 1'b0);   // b larger
    send(32'h3FFFFFFF, 32'h3FFFFFFF, 1'b0);
    send(32'hFFFFFFFF, 32'h00000000, 1'b0);
    send_random(200);
    send_idle = 72;
    send_random(150);
    send_idle = 0; recv_stall = 72;
    send_random(150);
    send_idle = 15; recv_stall = 15;
    send_random(150);
    // long hold-off so the block fills and stalls its input
    send_idle = 0; recv_stall = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (60) @(posedge clk);
        hold_off <= 1'b0;
      end
      send_random(40);
    join
    send_random(110);
    in_ch.valid <= 1'b0;
    while (pending_sums != 0) @(posedge clk);
    in_flight = 1'b0;
    repeat (10) @(posedge clk);
    $display("covered %0d results over idle, stall and hold-off phases", sums_checked);
    $display("directed extremes, cancellation, near/far alignment, overflow included");
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
